>>> src/escaped_rle_byte_decoder_assert.svh
// Assertion macros used by the decoder checker.
`ifndef ESCAPED_RLE_BYTE_DECODER_ASSERT_SVH
`define ESCAPED_RLE_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define ERBD_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erbd assertion failed");

// Next-cycle implication, masked during reset.
`define ERBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erbd assertion failed");

// Next-cycle implication that also checks the reset itself.
`define ERBD_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("erbd reset assertion failed");

`endif

>>> src/erbd_pkg.sv
// Types, codes and constants of the escaped run-length byte decoder.
package erbd_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int LIMIT_WIDTH = 24;
   localparam int LENGTH_WIDTH = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] COUNT_FULL = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam logic [LIMIT_WIDTH-1:0] COUNT_MAX =
      (COUNT_WIDTH >= LIMIT_WIDTH) ? '1 : COUNT_FULL[LIMIT_WIDTH-1:0];
   localparam logic [LIMIT_WIDTH-1:0] OUT_LIMIT_RESET = 24'd524288;

   localparam logic [7:0] ESC_BYTE     = 8'h00;
   localparam logic [7:0] CMD_ZERO_RUN = 8'h00;
   localparam logic [7:0] CMD_LITERAL  = 8'h01;
   localparam logic [7:0] CMD_RUN      = 8'h02;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_WANT_LO,
      PH_WANT_HI,
      PH_WANT_LIT,
      PH_WANT_CNT,
      PH_WANT_RUN
   } phase_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_RUN,
      OP_CHECK,
      OP_ERR
   } op_type;

   typedef enum logic [1:0] {
      KIND_RUN   = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      HALT_RUNNING,
      HALT_LIMIT,
      HALT_ERROR
   } halt_type;

   typedef struct packed {
      op_type                  op;
      logic [7:0]              value;
      logic [LENGTH_WIDTH-1:0] count;
      logic                    last;
      logic                    incomplete;
   } cmd_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              value;
      logic [LENGTH_WIDTH-1:0] length;
      logic [LIMIT_WIDTH-1:0]  total;
      logic                    last;
   } rsp_type;

endpackage

>>> src/erbd_front.sv
// Token parser: classifies each compressed byte into a command for the back end.
module erbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   input  logic             queue_full,
   output logic             cmd_push,
   output erbd_pkg::cmd_type cmd
);
   import erbd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       err_ff, err_in;
   logic [7:0] cnt_lo_ff, cnt_lo_in;
   logic       accept;

   assign accept = req_push && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         err_ff    <= 1'b0;
         cnt_lo_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         cnt_lo_ff <= cnt_lo_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      err_in         = err_ff;
      cnt_lo_in      = cnt_lo_ff;
      cmd            = '0;
      cmd.op         = OP_NONE;
      cmd.last       = req_in_last;
      cmd_push       = 1'b0;
      if (accept) begin
         if (!err_ff) begin
            case (phase_ff)
               PH_ESC: begin
                  if (req_in_byte == CMD_ZERO_RUN) begin
                     phase_in = PH_WANT_LO;
                  end else if (req_in_byte == CMD_LITERAL) begin
                     phase_in = PH_WANT_LIT;
                  end else if (req_in_byte == CMD_RUN) begin
                     phase_in = PH_WANT_CNT;
                  end else begin
                     cmd.op   = OP_ERR;
                     err_in   = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_WANT_LO: begin
                  cnt_lo_in = req_in_byte;
                  phase_in  = PH_WANT_HI;
               end
               PH_WANT_HI: begin
                  cmd.op    = OP_RUN;
                  cmd.value = ESC_BYTE;
                  cmd.count = {req_in_byte, cnt_lo_ff};
                  phase_in  = PH_IDLE;
               end
               PH_WANT_LIT: begin
                  cmd.op    = OP_RUN;
                  cmd.value = req_in_byte;
                  cmd.count = LENGTH_WIDTH'(1);
                  phase_in  = PH_IDLE;
               end
               PH_WANT_CNT: begin
                  cnt_lo_in = req_in_byte;
                  phase_in  = PH_WANT_RUN;
               end
               PH_WANT_RUN: begin
                  cmd.op    = OP_RUN;
                  cmd.value = req_in_byte;
                  cmd.count = LENGTH_WIDTH'(cnt_lo_ff);
                  phase_in  = PH_IDLE;
               end
               default: begin
                  if (req_in_byte == ESC_BYTE) begin
                     cmd.op   = OP_CHECK;
                     phase_in = PH_ESC;
                  end else begin
                     cmd.op    = OP_RUN;
                     cmd.value = req_in_byte;
                     cmd.count = LENGTH_WIDTH'(1);
                     phase_in  = PH_IDLE;
                  end
               end
            endcase
         end
         cmd.incomplete = !err_in && (phase_in != PH_IDLE);
         cmd_push       = (cmd.op != OP_NONE) || req_in_last;
         if (req_in_last) begin
            phase_in  = PH_IDLE;
            err_in    = 1'b0;
            cnt_lo_in = '0;
         end
      end
   end

endmodule

>>> src/erbd_cmd_queue.sv
// Short command queue between the parser and the run executor.
module erbd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  erbd_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output erbd_pkg::cmd_type pop_data,
   output logic              not_empty
);
   import erbd_pkg::*;

   cmd_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   assign full      = (cnt_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/erbd_back.sv
// Run executor: applies the output limit, tracks the stream total and buffers results.
module erbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [erbd_pkg::LIMIT_WIDTH-1:0]    out_limit,
   input  logic                                cmd_valid,
   input  erbd_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output erbd_pkg::rsp_type                   rsp
);
   import erbd_pkg::*;

   halt_type               halt_ff, halt_in, halt_upd;
   logic [LIMIT_WIDTH-1:0] bytes_ff, bytes_in, bytes_upd;
   logic                   sub_ff, sub_in;
   logic [LIMIT_WIDTH-1:0] lim, room, cnt_ext, len;
   logic                   running, run_emit, err_emit, failed;
   logic                   can_push, res_valid, res_push;
   rsp_type                res;

   rsp_type                buf_ff [2];
   logic                   head_ff, head_in;
   logic [1:0]             out_cnt_ff, out_cnt_in;
   logic                   out_pop;
   logic                   tail;

   assign lim     = (out_limit < COUNT_MAX) ? out_limit : COUNT_MAX;
   assign room    = (bytes_ff < lim) ? lim - bytes_ff : '0;
   assign cnt_ext = LIMIT_WIDTH'(cmd.count);
   assign len     = (cnt_ext < room) ? cnt_ext : room;
   assign running = (halt_ff == HALT_RUNNING);

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp       = buf_ff[head_ff];
   assign out_pop   = rsp_pop && !rsp_empty;
   assign can_push  = (out_cnt_ff != 2'd2) || out_pop;
   assign tail      = head_ff ^ out_cnt_ff[0];

   always_comb begin
      halt_upd  = halt_ff;
      bytes_upd = bytes_ff;
      run_emit  = 1'b0;
      err_emit  = 1'b0;
      if (!sub_ff) begin
         case (cmd.op)
            OP_RUN: begin
               if (running) begin
                  bytes_upd = bytes_ff + len;
                  run_emit  = (len != '0);
                  if (cnt_ext >= room) begin
                     halt_upd = HALT_LIMIT;
                  end
               end
            end
            OP_CHECK: begin
               if (running && (bytes_ff >= lim)) begin
                  halt_upd = HALT_LIMIT;
               end
            end
            OP_ERR: begin
               if (running) begin
                  halt_upd = HALT_ERROR;
                  err_emit = !cmd.last;
               end
            end
            default: begin
               halt_upd = halt_ff;
            end
         endcase
      end
      failed = (halt_upd == HALT_ERROR) ||
               ((halt_upd == HALT_RUNNING) && cmd.incomplete);
   end

   always_comb begin
      halt_in   = halt_ff;
      bytes_in  = bytes_ff;
      sub_in    = sub_ff;
      cmd_pop   = 1'b0;
      res       = '0;
      res.kind  = KIND_RUN;
      res.total = bytes_upd;
      res_valid = 1'b0;
      if (cmd_valid) begin
         if (run_emit) begin
            res.kind   = KIND_RUN;
            res.value  = cmd.value;
            res.length = len[LENGTH_WIDTH-1:0];
            res_valid  = 1'b1;
         end else if (err_emit) begin
            res.kind  = KIND_ERROR;
            res_valid = 1'b1;
         end else if (cmd.last) begin
            res.kind  = failed ? KIND_ERROR : KIND_DONE;
            res.last  = 1'b1;
            res_valid = 1'b1;
         end
         if (!res_valid || can_push) begin
            if (run_emit && cmd.last) begin
               // run result first; the final result of the stream follows once sub_ff is set
               halt_in  = halt_upd;
               bytes_in = bytes_upd;
               sub_in   = 1'b1;
            end else begin
               cmd_pop = 1'b1;
               sub_in  = 1'b0;
               if (cmd.last) begin
                  halt_in  = HALT_RUNNING;
                  bytes_in = '0;
               end else begin
                  halt_in  = halt_upd;
                  bytes_in = bytes_upd;
               end
            end
         end
      end
      res_push = res_valid && can_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff  <= HALT_RUNNING;
         bytes_ff <= '0;
         sub_ff   <= 1'b0;
      end else begin
         halt_ff  <= halt_in;
         bytes_ff <= bytes_in;
         sub_ff   <= sub_in;
      end
   end

   always_comb begin
      head_in    = out_pop ? ~head_ff : head_ff;
      out_cnt_in = out_cnt_ff;
      if (res_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !res_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         head_ff    <= head_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         buf_ff[tail] <= res;
      end
   end

endmodule

>>> src/escaped_rle_byte_decoder.sv
// Escaped run-length byte decoder: top level.
//
// Input queue port: present one compressed byte on req_in_byte with
// req_in_last on the final byte of a stream; a transaction completes at a
// clock edge with req_push high and req_full low. Result queue port: while
// rsp_empty is low the oldest result is on the rsp_ fields; rsp_pop takes it.
// Results are run descriptors (kind 0), a done result (kind 1) or an error
// (kind 2); the last result of a stream has rsp_last set.
// csr_write loads csr_wdata into the output byte limit of each stream.
// Throughput: one byte per cycle while req_full is low. A final byte that
// also completes a run makes the executor write two results, the run and
// then the final result, and hold its command until both are written.
// The parser and the executor are joined by a four-entry command queue and
// the executor feeds a two-entry result buffer, so a stalled receiver first
// fills these and then raises req_full; nothing is lost.
// Reset (synchronous, active high) empties both queues, returns the parser
// to token start, clears the stream total and sets the limit to 524288.
module escaped_rle_byte_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_run_value,
   output logic [15:0] rsp_run_length,
   output logic [23:0] rsp_total_length,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [23:0] csr_wdata
);
   import erbd_pkg::*;

   logic [LIMIT_WIDTH-1:0] out_limit_ff;
   logic                   cmd_push, queue_full, cmd_valid, cmd_pop;
   cmd_type                cmd_in, cmd_out;
   rsp_type                rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= OUT_LIMIT_RESET;
      end else if (csr_write) begin
         out_limit_ff <= csr_wdata;
      end
   end

   erbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (queue_full),
      .cmd_push    (cmd_push),
      .cmd         (cmd_in)
   );

   erbd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .not_empty (cmd_valid)
   );

   erbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .out_limit (out_limit_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign req_full         = queue_full;
   assign rsp_kind         = rsp.kind;
   assign rsp_run_value    = rsp.value;
   assign rsp_run_length   = rsp.length;
   assign rsp_total_length = rsp.total;
   assign rsp_last         = rsp.last;

endmodule

>>> src/erbd_checker.sv
// Port-level assertion checker for the decoder, bound to the top level.
`include "escaped_rle_byte_decoder_assert.svh"

module erbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_run_value,
   input logic [15:0] rsp_run_length,
   input logic [23:0] rsp_total_length,
   input logic        rsp_last
);
   import erbd_pkg::*;

   `ERBD_ASSERT(a_status_fields_zero, clock, reset,
      !rsp_empty && (rsp_kind != KIND_RUN), (rsp_run_value == 8'd0) && (rsp_run_length == 16'd0))
   `ERBD_ASSERT(a_run_shape, clock, reset,
      !rsp_empty && (rsp_kind == KIND_RUN), (rsp_run_length != 16'd0) && !rsp_last)
   `ERBD_ASSERT(a_last_is_status, clock, reset,
      !rsp_empty && rsp_last, (rsp_kind == KIND_DONE) || (rsp_kind == KIND_ERROR))
   `ERBD_ASSERT_NEXT(a_result_held, clock, reset,
      !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_kind) && $stable(rsp_total_length))
   `ERBD_ASSERT_RST(a_reset_empty, clock, reset, rsp_empty && !req_full)

endmodule

bind escaped_rle_byte_decoder erbd_checker u_erbd_checker (.*);

>>> tb/sv/tb_escaped_rle_byte_decoder.sv
// Self-checking testbench for the escaped run-length byte decoder.
module tb_escaped_rle_byte_decoder;
   import erbd_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 48;

   typedef struct packed {
      logic [7:0] b;
      logic       lst;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_run_value;
   logic [15:0] rsp_run_length;
   logic [23:0] rsp_total_length;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [23:0] csr_wdata = 24'd0;

   // decoder shadow state
   logic [23:0] limit_reg;
   phase_type   phase;
   logic [7:0]  cnt_lo;
   logic [7:0]  cnt_hi;
   logic [23:0] produced;
   halt_type    halt;

   rsp_type     step_results[$];
   rsp_type     decoded_queue[$];
   logic [7:0]  stream_bytes[$];
   int          fault_count = 0;
   int          stall_cycles = 0;
   int          pop_hold = 0;
   bit          steady = 1'b0;

   dir_row_type dir_rows[25] = '{
      '{8'h41, 1'b0, 1'b1, '{KIND_RUN, 8'h41, 16'd1, 24'd1, 1'b0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{KIND_RUN, 8'h00, 16'd1, 24'd2, 1'b0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{KIND_RUN, 8'h00, 16'd65535, 24'd65537, 1'b0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1, '{KIND_RUN, 8'h80, 16'd255, 24'd65792, 1'b0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h33, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_DONE, 8'h00, 16'd0, 24'd65792, 1'b1}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h07, 1'b0, 1'b1, '{KIND_ERROR, 8'h00, 16'd0, 24'd0, 1'b0}},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 16'd0, 24'd0, 1'b1}},
      '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 16'd0, 24'd0, 1'b1}}
   };

   escaped_rle_byte_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_run_value    (rsp_run_value),
      .rsp_run_length   (rsp_run_length),
      .rsp_total_length (rsp_total_length),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [23:0] cap_limit();
      return (limit_reg < COUNT_MAX) ? limit_reg : COUNT_MAX;
   endfunction

   function automatic void restart_stream();
      phase = PH_IDLE;
      cnt_lo = 8'h00;
      cnt_hi = 8'h00;
      produced = 24'd0;
      halt = HALT_RUNNING;
   endfunction

   function automatic void emit(kind_type k, logic [7:0] v, logic [15:0] len, logic l);
      rsp_type r;
      r.kind = k;
      r.value = v;
      r.length = len;
      r.total = produced;
      r.last = l;
      step_results.push_back(r);
   endfunction

   function automatic void add_run(logic [7:0] v, int unsigned count);
      int unsigned lim;
      int unsigned room;
      int unsigned len;
      lim = 32'(cap_limit());
      room = (32'(produced) < lim) ? lim - 32'(produced) : 0;
      len = (count < room) ? count : room;
      if (len > 0) begin
         produced = produced + len[23:0];
         emit(KIND_RUN, v, len[15:0], 1'b0);
      end
      if (32'(produced) >= lim) halt = HALT_LIMIT;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic lst);
      logic bad;
      bad = 1'b0;
      step_results.delete();
      if (halt == HALT_RUNNING) begin
         case (phase)
            PH_ESC: begin
               if (b == CMD_ZERO_RUN) phase = PH_WANT_LO;
               else if (b == CMD_LITERAL) phase = PH_WANT_LIT;
               else if (b == CMD_RUN) phase = PH_WANT_CNT;
               else begin
                  bad = 1'b1;
                  halt = HALT_ERROR;
                  phase = PH_IDLE;
               end
            end
            PH_WANT_LO: begin
               cnt_lo = b;
               phase = PH_WANT_HI;
            end
            PH_WANT_HI: begin
               cnt_hi = b;
               phase = PH_IDLE;
               add_run(8'h00, 32'({cnt_hi, cnt_lo}));
            end
            PH_WANT_LIT: begin
               phase = PH_IDLE;
               add_run(b, 1);
            end
            PH_WANT_CNT: begin
               cnt_lo = b;
               phase = PH_WANT_RUN;
            end
            PH_WANT_RUN: begin
               phase = PH_IDLE;
               add_run(b, 32'(cnt_lo));
            end
            default: begin
               phase = PH_IDLE;
               if (produced >= cap_limit()) halt = HALT_LIMIT;
               else if (b != ESC_BYTE) add_run(b, 1);
               else phase = PH_ESC;
            end
         endcase
      end
      if (lst) begin
         if (halt == HALT_ERROR || (halt == HALT_RUNNING && phase != PH_IDLE))
            emit(KIND_ERROR, 8'h00, 16'd0, 1'b1);
         else
            emit(KIND_DONE, 8'h00, 16'd0, 1'b1);
         restart_stream();
      end else if (bad) begin
         emit(KIND_ERROR, 8'h00, 16'd0, 1'b0);
      end
   endfunction

   function automatic void add_token();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(0, 9);
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      case (pick)
         0, 1, 2, 3: stream_bytes.push_back(8'($urandom_range(1, 255)));
         4, 5: begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(CMD_LITERAL);
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         6, 7: begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(CMD_RUN);
            stream_bytes.push_back(8'($urandom_range(0, 255)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(CMD_ZERO_RUN);
            stream_bytes.push_back(count[7:0]);
            stream_bytes.push_back(count[15:8]);
         end
      endcase
   endfunction

   // mostly well-formed streams; some noise, bad escapes and cut-off tokens
   function automatic void build_stream();
      int unsigned style;
      stream_bytes.delete();
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) add_token();
         if (style < 20) begin
            stream_bytes.push_back(ESC_BYTE);
            stream_bytes.push_back(8'($urandom_range(3, 255)));
            repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (style < 30) begin
            stream_bytes.push_back(ESC_BYTE);
            case ($urandom_range(0, 4))
               1: stream_bytes.push_back(CMD_LITERAL);
               2: stream_bytes.push_back(CMD_ZERO_RUN);
               3: begin
                  stream_bytes.push_back(CMD_ZERO_RUN);
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
               end
               4: begin
                  stream_bytes.push_back(CMD_RUN);
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
         end
      end
   endfunction

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fault_count++;
   endtask

   task automatic check_result();
      rsp_type want;
      if (decoded_queue.size() == 0) begin
         report($sformatf("unexpected transaction kind %0d total %0d", rsp_kind,
                          rsp_total_length));
      end else begin
         want = decoded_queue.pop_front();
         if (rsp_kind !== want.kind)
            report($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
         if (rsp_run_value !== want.value)
            report($sformatf("run_value %0h, want %0h", rsp_run_value, want.value));
         if (rsp_run_length !== want.length)
            report($sformatf("run_length %0d, want %0d", rsp_run_length, want.length));
         if (rsp_total_length !== want.total)
            report($sformatf("total_length %0d, want %0d", rsp_total_length, want.total));
         if (rsp_last !== want.last)
            report($sformatf("last %0b, want %0b", rsp_last, want.last));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                            input rsp_type want);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      req_in_last <= lst;
      do @(posedge clock); while (req_full);
      decode_byte(b, lst);
      if (typed) decoded_queue.push_back(want);
      else foreach (step_results[i]) decoded_queue.push_back(step_results[i]);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      limit_reg = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result();
         if (pop_hold > 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else if (!steady && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(0, 8);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("tb_escaped_rle_byte_decoder failed");
            $finish;
         end
      end
   end

   initial begin
      logic [23:0] limits[10];
      int sent;
      bit keep_open;
      limits = '{24'd3, 24'd0, 24'hFFFFFF, 24'd300, 24'd1, 24'd65535, 24'd7, 24'd1000,
                 24'd0, OUT_LIMIT_RESET};
      limit_reg = OUT_LIMIT_RESET;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < 10; p++) begin
         settle();
         write_limit(p == 8 ? 24'($urandom_range(0, 24'hFFFFFF)) : limits[p]);
         steady = (p == 9);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_stream();
            // a stream may stay open across the next limit write
            keep_open = !steady && (sent + stream_bytes.size() >= PHASE_ITEMS) &&
                        $urandom_range(0, 1);
            foreach (stream_bytes[i])
               send_byte(stream_bytes[i], (i == stream_bytes.size() - 1) && !keep_open,
                         1'b0, '0);
            sent += stream_bytes.size();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (fault_count == 0)
         $display("tb_escaped_rle_byte_decoder passed");
      else
         $display("tb_escaped_rle_byte_decoder failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/erbd_pkg.sv
src/erbd_front.sv
src/erbd_cmd_queue.sv
src/erbd_back.sv
src/escaped_rle_byte_decoder.sv
src/erbd_checker.sv
tb/sv/tb_escaped_rle_byte_decoder.sv
